[sv/mstk_pkg.sv]
// Shared types, codes and defaults for the multi-stack engine.
package mstk_pkg;

	// Default configuration of the engine
	localparam int NUM_STACKS_DEF = 3;
	localparam int MAX_DEPTH_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Capacity register
	localparam int         CAP_W     = 5;
	localparam logic [4:0] CAP_RESET = 5'd16;

	// Operation codes (any other code acts as a peek)
	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Input transaction
	typedef struct packed {
		logic [1:0]         func;
		logic [1:0]         stack_id;
		logic signed [31:0] push_value;
	} op_item_t;

	// Output transaction
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] top_value;
		logic [4:0]         count;
		logic               now_empty;
		logic               now_full;
	} op_result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_result;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic res_free;
	} dp_stat_t;

endpackage

[sv/mstk_ctrl.sv]
// Sequencer for the multi-stack engine: accept, execute, respond.
module mstk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mstk_pkg::dp_stat_t    stat,
	output mstk_pkg::ctrl_cmd_t   cmd
);
	import mstk_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (stat.res_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/mstk_dp.sv]
// Datapath of the multi-stack engine: counts, capacity, shared memory, result register.
module mstk_dp #(
	parameter int NUM_STACKS = mstk_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH  = mstk_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = mstk_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mstk_pkg::ctrl_cmd_t   cmd,
	output mstk_pkg::dp_stat_t    stat,
	input  mstk_pkg::op_item_t    item,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	output logic                  res_valid,
	input  logic                  res_stall,
	output mstk_pkg::op_result_t  result
);
	import mstk_pkg::*;

	localparam int MEM_DEPTH = NUM_STACKS * MAX_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int CW        = $clog2(MAX_DEPTH + 1);
	localparam int SW        = $clog2(NUM_STACKS);

	// Capacity as used: zero acts as one, large values clip to the slice size
	function automatic logic [CW-1:0] eff_cap_f(input logic [4:0] c);
		int v;
		v = int'(c);
		if (v == 0) v = 1;
		if (v > MAX_DEPTH) v = MAX_DEPTH;
		return CW'(v);
	endfunction

	op_item_t            item_q;
	logic [CW-1:0]       cap_q;
	logic [CW-1:0]       cnt_q [NUM_STACKS];
	logic [DATA_WIDTH-1:0] stack_mem_q [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic [1:0]          status_s2;
	logic [CW-1:0]       cnt_s2;
	logic                full_s2;
	logic                fwd_s2;
	logic [DATA_WIDTH-1:0] fwd_val_s2;

	logic                res_valid_q;
	op_result_t          result_q;

	logic                sel_ok;
	logic [SW-1:0]       sid;
	logic [CW-1:0]       cur_cnt;
	logic                is_push;
	logic                is_pop;
	logic                cur_full;
	logic                cur_empty;
	logic                push_ok;
	logic                pop_ok;
	logic [1:0]          status_d;
	logic [CW-1:0]       new_cnt;
	logic [AW:0]         base;
	logic [AW:0]         top_sum;
	logic [AW-1:0]       top_addr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] top_entry;

	// Operation decode against the selected stack
	assign sel_ok    = (32'(item_q.stack_id) < NUM_STACKS);
	assign sid       = SW'(item_q.stack_id);
	assign cur_cnt   = sel_ok ? cnt_q[sid] : '0;
	assign is_push   = (item_q.func == FUNC_PUSH);
	assign is_pop    = (item_q.func == FUNC_POP);
	assign cur_full  = (cur_cnt >= cap_q);
	assign cur_empty = (cur_cnt == '0);
	assign push_ok   = sel_ok && is_push && !cur_full;
	assign pop_ok    = sel_ok && is_pop && !cur_empty;
	assign wdata     = DATA_WIDTH'($unsigned(item_q.push_value));

	always_comb begin
		if (is_push) begin
			status_d = (!sel_ok || cur_full) ? STAT_FULL : STAT_OK;
		end else begin
			status_d = (!sel_ok || cur_empty) ? STAT_EMPTY : STAT_OK;
		end
	end

	always_comb begin
		if (push_ok) begin
			new_cnt = cur_cnt + CW'(1);
		end else if (pop_ok) begin
			new_cnt = cur_cnt - CW'(1);
		end else begin
			new_cnt = cur_cnt;
		end
	end

	// Top entry address; in range only for an existing stack that is not left empty
	assign base     = (AW + 1)'(sid) * (AW + 1)'(cap_q);
	assign top_sum  = base + (AW + 1)'(new_cnt) - (AW + 1)'(1);
	assign top_addr = top_sum[AW-1:0];

	// Input item and capacity register
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= eff_cap_f(CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= eff_cap_f(cfg_wdata);
		end
	end

	// Fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.exec && sel_ok) begin
			cnt_q[sid] <= new_cnt;
		end
	end

	// Shared memory: write on push, registered read otherwise
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			stack_mem_q[top_addr] <= wdata;
		end
		if (cmd.exec && !push_ok) begin
			rd_data_q <= stack_mem_q[top_addr];
		end
	end

	// Execute stage results
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_s2  <= status_d;
			cnt_s2     <= sel_ok ? new_cnt : '0;
			full_s2    <= sel_ok && (new_cnt >= cap_q);
			fwd_s2     <= push_ok;
			fwd_val_s2 <= wdata;
		end
	end

	// Pushed value is the new top; skip the memory for it
	assign top_entry = fwd_s2 ? fwd_val_s2 : rd_data_q;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q.status    <= status_s2;
			result_q.top_value <= (cnt_s2 == '0) ? '0 : $signed(32'(top_entry));
			result_q.count     <= 5'(cnt_s2);
			result_q.now_empty <= (cnt_s2 == '0);
			result_q.now_full  <= full_s2;
		end
	end

	assign stat.res_free = !res_valid_q || !res_stall;
	assign res_valid     = res_valid_q;
	assign result        = result_q;

endmodule

[sv/multi_stack_in_one_memory_top.sv]
// Top level of the multi-stack engine: controller plus datapath.
//
// NUM_STACKS stacks share one memory; stack s owns the slice that starts at
// s * capacity. The capacity register is written through the cfg channel
// (cfg_valid/cfg_ready, ready always high); the user must write it only
// while the engine is idle, as the block itself does not enforce this.
// Input transactions (in_valid/in_stall, payload in_data) push, pop or peek
// one stack. Each yields one output transaction (out_valid/out_stall,
// payload out_data) with status, new top value, count and flags.
// The controller accepts an item in S_IDLE, executes it in S_EXEC (one
// memory write or one registered read), loads its result into the output
// register in S_RESP once that is free, and only then takes another item.
// The next item is accepted while a finished result still waits in the
// output register. If the receiver stalls and the output register is full,
// the next result holds in the datapath and input stays stalled.
// Reset clears all counts, sets capacity to 16 and empties the output; the
// memory is not cleared (the top value of an empty stack reads as zero).
module multi_stack_in_one_memory_top #(
	parameter int NUM_STACKS = mstk_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH  = mstk_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = mstk_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mstk_pkg::op_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mstk_pkg::op_result_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [4:0]            cfg_data
);
	import mstk_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	mstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mstk_dp #(
		.NUM_STACKS (NUM_STACKS),
		.MAX_DEPTH  (MAX_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.result    (out_data)
	);

	// One item at a time: an accepted transaction stalls the input next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item was in flight");

	// An empty stack reports no entries and a zero top
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.now_empty |-> out_data.count == 5'd0 &&
			out_data.top_value == 32'sd0)
		else $error("empty result with nonzero count or top");

	// An empty error always leaves the stack empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_EMPTY |-> out_data.now_empty)
		else $error("empty status on a nonempty stack");

endmodule

[sim/multi_stack_in_one_memory_top_tb.sv]
// Testbench for the multi-stack engine: directed and burst stimulus, scoreboard with predictor.
`timescale 1ns / 1ps

module multi_stack_in_one_memory_top_tb;
	import mstk_pkg::*;

	localparam int NSTK  = NUM_STACKS_DEF;
	localparam int DEPTH = MAX_DEPTH_DEF;
	localparam int SLOTS = NSTK * DEPTH;

	// Operation code outside the defined set; the engine treats it as a peek
	localparam logic [1:0] FUNC_UNDEF = 2'd3;
	// Stack index past the last stack
	localparam logic [1:0] STACK_NONE = 2'(NSTK);

	// Tracks stack contents and the expected result of every accepted transaction
	class stack_scoreboard;
		logic [31:0]  slot_data [SLOTS];
		int unsigned  fill_count [NSTK];
		logic [4:0]   capacity;
		op_result_t   expected_q [$];
		int unsigned  ops_seen;
		int unsigned  results_seen;
		int unsigned  mismatches;

		function new();
			capacity = CAP_RESET;
			foreach (fill_count[i]) fill_count[i] = 0;
			foreach (slot_data[i]) slot_data[i] = '0;
			ops_seen = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void write_capacity(logic [4:0] v);
			capacity = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// 0 acts as 1, anything past the depth acts as the depth
		function int unsigned eff_capacity();
			if (capacity == 0) return 1;
			if (capacity > DEPTH) return DEPTH;
			return 32'(capacity);
		endfunction

		function int unsigned top_slot(int unsigned s, int unsigned cap);
			int unsigned a;
			a = s * cap + fill_count[s] - 1;
			return (a < SLOTS) ? a : SLOTS - 1;
		endfunction

		function void note_op(op_item_t op);
			int unsigned cap;
			int unsigned s;
			op_result_t  r;
			cap = eff_capacity();
			s = 32'(op.stack_id);
			ops_seen++;
			r = '0;
			r.status = STAT_OK;
			if (s >= NSTK) begin
				r.status = (op.func == FUNC_PUSH) ? STAT_FULL : STAT_EMPTY;
				r.now_empty = 1'b1;
			end else begin
				case (op.func)
				FUNC_PUSH: begin
					if (fill_count[s] >= cap) begin
						r.status = STAT_FULL;
					end else begin
						fill_count[s]++;
						slot_data[top_slot(s, cap)] = op.push_value;
					end
				end
				FUNC_POP: begin
					if (fill_count[s] == 0) r.status = STAT_EMPTY;
					else fill_count[s]--;
				end
				default: begin
					if (fill_count[s] == 0) r.status = STAT_EMPTY;
				end
				endcase
				r.count = 5'(fill_count[s]);
				r.now_empty = (fill_count[s] == 0);
				r.now_full = (fill_count[s] >= cap);
				if (fill_count[s] != 0) r.top_value = slot_data[top_slot(s, cap)];
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(op_result_t got);
			op_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected: status %0d top %0d count %0d",
						results_seen, got.status, got.top_value, got.count);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.top_value !== want.top_value ||
					got.count !== want.count || got.now_empty !== want.now_empty ||
					got.now_full !== want.now_full) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result %0d mismatch: expected status %0d top %0d count %0d ",
						"empty %b full %b, got status %0d top %0d count %0d empty %b full %b"},
						results_seen, want.status, want.top_value, want.count,
						want.now_empty, want.now_full, got.status, got.top_value,
						got.count, got.now_empty, got.now_full);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	op_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	op_result_t  out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;

	stack_scoreboard tracker;
	int send_idle_pct;
	int recv_stall_pct;
	int cfg_writes;

	multi_stack_in_one_memory_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stall, updated on the falling edge
	always @(negedge clk) begin
		out_stall <= arst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b0;
	end

	// Monitor: note accepted transactions, check delivered results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) tracker.note_op(in_data);
			if (out_valid && !out_stall) tracker.check_result(out_data);
		end
	end

	// Hard limit on run time
	initial begin
		#2_000_000;
		$display("multi_stack_in_one_memory_top verification failed");
		$finish;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return '1;
		3: return '0;
		default: return $urandom;
		endcase
	endfunction

	// Present one transaction, with optional idle cycles ahead of it
	task automatic send_op(logic [1:0] func, logic [1:0] sid, logic [31:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_data.func <= 2'($urandom_range(3));
			in_data.stack_id <= 2'($urandom_range(3));
			in_data.push_value <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: func, stack_id: sid, push_value: value};
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain();
		int guard;
		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (tracker.pending() != 0 && guard < 100_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cap(logic [4:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_capacity(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly push or pop bursts on one stack, with peeks and stray items mixed in
	task automatic run_bursts(int n);
		int sent;
		int len;
		logic [1:0] sid;
		bit grow;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 8) begin
				send_op(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom);
				sent++;
			end else begin
				sid = 2'($urandom_range(NSTK - 1));
				grow = 1'($urandom_range(1));
				len = $urandom_range(1, 18);
				repeat (len) begin
					if ($urandom_range(99) < 15)
						send_op($urandom_range(1) ? FUNC_PEEK : FUNC_UNDEF, sid, $urandom);
					else
						send_op(grow ? FUNC_PUSH : FUNC_POP, sid, pick_value());
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [4:0] caps [8];
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_writes = 0;
		caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd17, 5'd0};
		caps[7] = 5'($urandom_range(1, DEPTH));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty errors, missing stack, odd opcode, value extremes
		send_op(FUNC_POP, 2'd0, '0);
		send_op(FUNC_PEEK, 2'd1, '0);
		send_op(FUNC_UNDEF, 2'd2, '0);
		send_op(FUNC_PUSH, STACK_NONE, 32'h1234_5678);
		send_op(FUNC_POP, STACK_NONE, '0);
		send_op(FUNC_PEEK, STACK_NONE, '0);
		send_op(FUNC_UNDEF, STACK_NONE, '0);
		send_op(FUNC_PUSH, 2'd0, 32'h8000_0000);
		send_op(FUNC_PUSH, 2'd0, 32'h7fff_ffff);
		send_op(FUNC_PUSH, 2'd0, '0);
		send_op(FUNC_PUSH, 2'd0, '1);
		send_op(FUNC_PEEK, 2'd0, '0);
		send_op(FUNC_POP, 2'd0, '0);
		send_op(FUNC_UNDEF, 2'd0, '0);
		send_op(FUNC_PUSH, 2'd1, 32'd1);
		send_op(FUNC_PUSH, 2'd2, 32'h5555_5555);
		send_op(FUNC_PUSH, 2'd2, 32'haaaa_aaaa);
		send_op(FUNC_POP, 2'd2, '0);
		send_op(FUNC_POP, 2'd1, '0);
		send_op(FUNC_POP, 2'd1, '0);

		// Fill every stack past full at capacity 16 so every slot is written
		for (int s = 0; s < NSTK; s++)
			repeat (DEPTH + 1) send_op(FUNC_PUSH, 2'(s), pick_value());

		// Random phases; capacity changes while stacks still hold entries
		for (int seg = 0; seg < 8; seg++) begin
			write_cap(caps[seg]);
			case (seg / 2)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			run_bursts(100);
		end

		drain();
		repeat (10) @(posedge clk);
		$display("%0d operations sent and %0d results checked over %0d capacity writes",
			tracker.ops_seen, tracker.results_seen, cfg_writes);
		$display("capacities 0, 1, 2, 5, 16, 17, 31 with mixed sender idle and receiver stall");
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("multi_stack_in_one_memory_top verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				tracker.mismatches, tracker.pending());
			$display("multi_stack_in_one_memory_top verification failed");
		end
		$finish;
	end

endmodule
